// ===== hw/rtl/kpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kpp_pkg;

   localparam int MAX_KEYS = 64;
   localparam int ADDR_W   = $clog2(MAX_KEYS);
   localparam int COUNT_W  = $clog2(MAX_KEYS + 1);

   localparam int DATA_W   = 32;
   localparam int NUM_CH   = 4;
   localparam int CH_W     = $clog2(NUM_CH);
   localparam int KEY_W    = DATA_W * NUM_CH;

   localparam int FRAC_W   = 18;
   localparam int STEP_W   = 16;
   localparam int DIFF_W   = DATA_W + 1;
   localparam int PROD_W   = DIFF_W + FRAC_W + 1;
   localparam int Q_W      = PROD_W - STEP_W;
   localparam int SUM_W    = Q_W + 2;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(328);
   localparam logic [FRAC_W-1:0] ONE_Q16    = FRAC_W'(65536);
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

   localparam logic signed [DATA_W-1:0] POSE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] POSE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_START  = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] key_x;
      logic signed [DATA_W-1:0] key_y;
      logic signed [DATA_W-1:0] key_z;
      logic signed [DATA_W-1:0] key_yaw;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pose_x;
      logic signed [DATA_W-1:0] pose_y;
      logic signed [DATA_W-1:0] pose_z;
      logic signed [DATA_W-1:0] pose_yaw;
      logic                     is_playing;
      logic [1:0]               status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     valid;
      logic [CH_W-1:0]          ch;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic [FRAC_W-1:0]        frac;
   } lerp_req_type;

   typedef struct packed {
      logic                     valid;
      logic [CH_W-1:0]          ch;
      logic signed [DATA_W-1:0] pose;
   } lerp_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/kpp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpp_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 128,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_a,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/kpp_lerp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpp_lerp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kpp_pkg::lerp_req_type req,
   output kpp_pkg::lerp_rsp_type      rsp
);

   // stage 1: difference
   logic                                    s1_valid_ff, s1_valid_in;
   logic [kpp_pkg::CH_W-1:0]                s1_ch_ff, s1_ch_in;
   logic signed [kpp_pkg::DIFF_W-1:0]       s1_diff_ff, s1_diff_in;
   logic signed [kpp_pkg::DATA_W-1:0]       s1_a_ff, s1_a_in;
   logic [kpp_pkg::FRAC_W-1:0]              s1_frac_ff, s1_frac_in;

   // stage 2: product
   logic                                    s2_valid_ff, s2_valid_in;
   logic [kpp_pkg::CH_W-1:0]                s2_ch_ff, s2_ch_in;
   logic signed [kpp_pkg::PROD_W-1:0]       s2_prod_ff, s2_prod_in;
   logic signed [kpp_pkg::DATA_W-1:0]       s2_a_ff, s2_a_in;

   // stage 3: round, offset, saturate
   logic                                    out_valid_ff, out_valid_in;
   logic [kpp_pkg::CH_W-1:0]                out_ch_ff, out_ch_in;
   logic signed [kpp_pkg::DATA_W-1:0]       out_pose_ff, out_pose_in;

   logic signed [kpp_pkg::PROD_W-1:0]       rounded;
   logic signed [kpp_pkg::Q_W-1:0]          scaled;
   logic signed [kpp_pkg::SUM_W-1:0]        total;
   logic [kpp_pkg::SUM_W-kpp_pkg::DATA_W:0] top_bits;

   always_comb begin
      s1_valid_in = req.valid;
      s1_ch_in    = req.ch;
      s1_a_in     = req.a;
      s1_frac_in  = req.frac;
      s1_diff_in  = $signed({req.b[kpp_pkg::DATA_W-1], req.b})
                  - $signed({req.a[kpp_pkg::DATA_W-1], req.a});
   end

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_ch_in    = s1_ch_ff;
      s2_a_in     = s1_a_ff;
      s2_prod_in  = s1_diff_ff * $signed({1'b0, s1_frac_ff});
   end

   always_comb begin
      rounded  = s2_prod_ff + kpp_pkg::ROUND_HALF;
      scaled   = rounded[kpp_pkg::PROD_W-1:kpp_pkg::STEP_W];
      total    = $signed({{2{scaled[kpp_pkg::Q_W-1]}}, scaled})
               + $signed({{(kpp_pkg::SUM_W-kpp_pkg::DATA_W){s2_a_ff[kpp_pkg::DATA_W-1]}},
                          s2_a_ff});
      top_bits = total[kpp_pkg::SUM_W-1:kpp_pkg::DATA_W-1];
      out_valid_in = s2_valid_ff;
      out_ch_in    = s2_ch_ff;
      if ((&top_bits) || !(|top_bits)) begin
         out_pose_in = total[kpp_pkg::DATA_W-1:0];
      end else if (total[kpp_pkg::SUM_W-1]) begin
         out_pose_in = kpp_pkg::POSE_MIN;
      end else begin
         out_pose_in = kpp_pkg::POSE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ch_ff    <= s1_ch_in;
      s1_diff_ff  <= s1_diff_in;
      s1_a_ff     <= s1_a_in;
      s1_frac_ff  <= s1_frac_in;
      s2_ch_ff    <= s2_ch_in;
      s2_prod_ff  <= s2_prod_in;
      s2_a_ff     <= s2_a_in;
      out_ch_ff   <= out_ch_in;
      out_pose_ff <= out_pose_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.ch    = out_ch_ff;
   assign rsp.pose  = out_pose_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/keyframe_pose_player.sv =====
// Keyframe pose player: stores up to 64 poses (x, y, z, yaw, signed Q16.16) and plays them back
// by linear interpolation between neighboring keys. req_data.mode selects tick, append, start or
// clear; every transfer on req_ gives exactly one transfer on rsp_ with the held pose, the playing
// flag and a status (ok, start refused, table full). csr_wdata sets the fraction step per tick
// (Q0.16, reset 328). The block takes one item at a time: a tick during playback passes through
// decode, a registered key memory read, the four pose channels issued one per cycle into the
// single shared three-stage multiply and round pipeline, drain and result; any other item passes
// through decode and result only. Either waits at result while the output is stalled. A new item
// may be taken while the previous result still sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_pose_player (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire kpp_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output kpp_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_write,
   input  wire logic [kpp_pkg::STEP_W-1:0]  csr_wdata
);

   kpp_pkg::state_type                state_ff, state_in;
   kpp_pkg::req_type                  req_ff, req_in;
   logic [kpp_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [kpp_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [kpp_pkg::ADDR_W-1:0]        seg_ff, seg_in;
   logic [kpp_pkg::FRAC_W-1:0]        frac_ff, frac_in;
   logic [kpp_pkg::FRAC_W-1:0]        blend_ff, blend_in;
   logic                              playing_ff, playing_in;
   logic [1:0]                        status_ff, status_in;
   logic [kpp_pkg::CH_W-1:0]          ch_ff, ch_in;
   logic signed [kpp_pkg::DATA_W-1:0] held_ff [kpp_pkg::NUM_CH];
   logic                              rsp_valid_ff, rsp_valid_in;
   kpp_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic                              req_xfer;
   logic                              slot_free;
   logic                              can_play;
   logic                              rsp_load;
   logic                              ram_we;
   logic [kpp_pkg::ADDR_W-1:0]        rd_addr_b;
   logic [kpp_pkg::KEY_W-1:0]         ram_wdata;
   logic [kpp_pkg::KEY_W-1:0]         rd_data_a;
   logic [kpp_pkg::KEY_W-1:0]         rd_data_b;
   logic                              wrap;
   logic [kpp_pkg::COUNT_W-1:0]       seg_next;
   logic [kpp_pkg::FRAC_W-1:0]        frac_use;
   kpp_pkg::lerp_req_type             lerp_req;
   kpp_pkg::lerp_rsp_type             lerp_rsp;

   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign can_play  = playing_ff && (count_ff >= kpp_pkg::COUNT_W'(2));
   assign rd_addr_b = seg_ff + kpp_pkg::ADDR_W'(1);
   assign ram_wdata = {req_ff.key_yaw, req_ff.key_z, req_ff.key_y, req_ff.key_x};

   kpp_ram #(
      .DEPTH (kpp_pkg::MAX_KEYS),
      .WIDTH (kpp_pkg::KEY_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (count_ff[kpp_pkg::ADDR_W-1:0]),
      .wr_data   (ram_wdata),
      .rd_addr_a (seg_ff),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   kpp_lerp u_lerp (
      .clock (clock),
      .reset (reset),
      .req   (lerp_req),
      .rsp   (lerp_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kpp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = kpp_pkg::ST_DECODE;
            end
         end
         kpp_pkg::ST_DECODE: begin
            if (req_ff.mode == kpp_pkg::MODE_TICK && can_play) begin
               state_in = kpp_pkg::ST_READ;
            end else begin
               state_in = kpp_pkg::ST_DONE;
            end
         end
         kpp_pkg::ST_READ: begin
            state_in = kpp_pkg::ST_ISSUE;
         end
         kpp_pkg::ST_ISSUE: begin
            if (ch_ff == kpp_pkg::CH_W'(kpp_pkg::NUM_CH - 1)) begin
               state_in = kpp_pkg::ST_DRAIN;
            end
         end
         kpp_pkg::ST_DRAIN: begin
            if (lerp_rsp.valid && lerp_rsp.ch == kpp_pkg::CH_W'(kpp_pkg::NUM_CH - 1)) begin
               state_in = kpp_pkg::ST_DONE;
            end
         end
         kpp_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = kpp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kpp_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_stall      = (state_ff != kpp_pkg::ST_IDLE);
      ram_we         = (state_ff == kpp_pkg::ST_DECODE)
                    && (req_ff.mode == kpp_pkg::MODE_APPEND)
                    && (count_ff < kpp_pkg::COUNT_W'(kpp_pkg::MAX_KEYS));
      rsp_load       = (state_ff == kpp_pkg::ST_DONE) && slot_free;
      lerp_req.valid = (state_ff == kpp_pkg::ST_ISSUE);
      lerp_req.ch    = ch_ff;
      lerp_req.a     = rd_data_a[ch_ff * kpp_pkg::DATA_W +: kpp_pkg::DATA_W];
      lerp_req.b     = rd_data_b[ch_ff * kpp_pkg::DATA_W +: kpp_pkg::DATA_W];
      lerp_req.frac  = blend_ff;
   end

   // segment advance for a playing tick
   always_comb begin
      wrap     = (frac_ff > kpp_pkg::ONE_Q16);
      frac_use = wrap ? '0 : frac_ff;
      seg_next = {1'b0, seg_ff} + (wrap ? kpp_pkg::COUNT_W'(1) : '0);
   end

   // datapath next values
   always_comb begin
      req_in     = req_xfer ? req_data : req_ff;
      step_in    = csr_write ? csr_wdata : step_ff;
      count_in   = count_ff;
      seg_in     = seg_ff;
      frac_in    = frac_ff;
      blend_in   = blend_ff;
      playing_in = playing_ff;
      status_in  = status_ff;
      ch_in      = ch_ff;
      if (state_ff == kpp_pkg::ST_DECODE) begin
         status_in = kpp_pkg::STATUS_OK;
         unique case (req_ff.mode)
            kpp_pkg::MODE_TICK: begin
               if (can_play) begin
                  if (seg_next >= count_ff - kpp_pkg::COUNT_W'(1)) begin
                     seg_in     = '0;
                     playing_in = 1'b0;
                  end else begin
                     seg_in = seg_next[kpp_pkg::ADDR_W-1:0];
                  end
                  blend_in = frac_use;
                  frac_in  = frac_use + {{(kpp_pkg::FRAC_W-kpp_pkg::STEP_W){1'b0}}, step_ff};
               end
            end
            kpp_pkg::MODE_APPEND: begin
               if (count_ff < kpp_pkg::COUNT_W'(kpp_pkg::MAX_KEYS)) begin
                  count_in = count_ff + kpp_pkg::COUNT_W'(1);
               end else begin
                  status_in = kpp_pkg::STATUS_FULL;
               end
            end
            kpp_pkg::MODE_START: begin
               if (count_ff > kpp_pkg::COUNT_W'(1)) begin
                  playing_in = 1'b1;
                  seg_in     = '0;
                  frac_in    = '0;
               end else begin
                  status_in = kpp_pkg::STATUS_REFUSED;
               end
            end
            kpp_pkg::MODE_CLEAR: begin
               count_in   = '0;
               playing_in = 1'b0;
               seg_in     = '0;
               frac_in    = '0;
            end
            default: begin
               status_in = kpp_pkg::STATUS_OK;
            end
         endcase
      end
      if (state_ff == kpp_pkg::ST_READ) begin
         ch_in = '0;
      end else if (state_ff == kpp_pkg::ST_ISSUE) begin
         ch_in = ch_ff + kpp_pkg::CH_W'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.pose_x     = held_ff[0];
         rsp_data_in.pose_y     = held_ff[1];
         rsp_data_in.pose_z     = held_ff[2];
         rsp_data_in.pose_yaw   = held_ff[3];
         rsp_data_in.is_playing = playing_ff;
         rsp_data_in.status     = status_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpp_pkg::ST_IDLE;
         step_ff      <= kpp_pkg::STEP_RESET;
         count_ff     <= '0;
         seg_ff       <= '0;
         frac_ff      <= '0;
         playing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         seg_ff       <= seg_in;
         frac_ff      <= frac_in;
         playing_ff   <= playing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kpp_pkg::NUM_CH; i++) begin
            held_ff[i] <= '0;
         end
      end else if (lerp_rsp.valid) begin
         held_ff[lerp_rsp.ch] <= lerp_rsp.pose;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      blend_ff    <= blend_in;
      status_ff   <= status_in;
      ch_ff       <= ch_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/kpp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpp_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire kpp_pkg::req_type           req_data,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire kpp_pkg::rsp_type           rsp_data,
   input  wire logic                       csr_write,
   input  wire logic [kpp_pkg::STEP_W-1:0] csr_wdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // one item at a time: busy right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while previous item still in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == kpp_pkg::STATUS_OK
                  || rsp_data.status == kpp_pkg::STATUS_REFUSED
                  || rsp_data.status == kpp_pkg::STATUS_FULL))
      else $error("undefined status code");

   // a refused start means fewer than two keys, so playback cannot run
   a_refused_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == kpp_pkg::STATUS_REFUSED |-> !rsp_data.is_playing)
      else $error("refused start reported while playing");

   logic unused_ok;
   assign unused_ok = ^{req_data, csr_write, csr_wdata};

endmodule

bind keyframe_pose_player kpp_checker u_kpp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_write (csr_write),
   .csr_wdata (csr_wdata)
);

`default_nettype wire
